// ===== src/assert_macros.svh =====
// assertion macros, included by the accumulator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lpda_pkg.sv =====
// constants and command codes of the leibniz pi decimal accumulator
`timescale 1ns / 1ps

package lpda_pkg;

	localparam int DIGITS      = 256;
	localparam int COUNT_BITS  = 20;
	localparam int ADDR_W      = $clog2(DIGITS);
	localparam int DIV_W       = COUNT_BITS + 1;
	localparam int PART_W      = DIV_W + 4;
	localparam int TERMS_W     = 20;
	localparam int DIGIT_W     = 4;
	localparam int START_UNITS = 4;
	localparam int RADIX       = 10;

	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DIGITS - 1);

	typedef enum logic [1:0] {
		CMD_STEP  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

endpackage

// ===== src/lpda_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lpda_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/leibniz_pi_decimal_accumulator_core.sv =====
// leibniz pi accumulator: decimal digit sum in ram, long divide and add/sub sweeps
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  request | req_valid | req_stall | command, digit_index
//  result  | rsp_valid | rsp_stall | digit_value, terms_done, refused
//
// a step runs the divide unit, which works out one quotient digit per sum digit into
// the term ram, then one pass over the sum ram, one digit per cycle
// a read answers after the registered ram read; clear, refused step and unused command at once
// reset clears per-digit valid bits, so the sum reads as 4.000... at once, no sweep
// one request at a time; a waiting result holds off the next request, which may
// enter on the cycle the result is taken
`timescale 1ns / 1ps
`include "assert_macros.svh"

module leibniz_pi_decimal_accumulator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         command,
	input  logic [7:0]                         digit_index,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [lpda_pkg::DIGIT_W-1:0]       digit_value,
	output logic [lpda_pkg::TERMS_W-1:0]       terms_done,
	output logic                               refused
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_DIV,
		ST_PRIME,
		ST_SUM
	} state_t;

	state_t state_q;

	// result register
	logic                                rsp_valid_q;
	logic [lpda_pkg::DIGIT_W-1:0]        digit_q;
	logic [lpda_pkg::TERMS_W-1:0]        terms_q;
	logic                                refused_q;

	// series state
	logic [lpda_pkg::COUNT_BITS-1:0]     term_count_q;
	logic [lpda_pkg::DIGITS-1:0]         sum_vld_q;

	// divide unit
	logic [lpda_pkg::DIV_W-1:0]          div_q;
	logic [lpda_pkg::PART_W-1:0]         part_q;
	logic [1:0]                          bit_q;
	logic [2:0]                          q_q;

	// digit sweep
	logic [lpda_pkg::ADDR_W-1:0]         k_q;
	logic                                sub_q;
	logic                                cy_q;
	logic                                in_range_q;

	// ram read side registers, aligned with the ram output
	logic                                rd_vld_s1;
	logic                                rd_zero_s1;

	// ram ports
	logic                                sum_re;
	logic [lpda_pkg::ADDR_W-1:0]         sum_raddr;
	logic [lpda_pkg::DIGIT_W-1:0]        sum_rdata;
	logic                                sum_we;
	logic [lpda_pkg::DIGIT_W-1:0]        sum_wdata;
	logic                                term_we;
	logic [lpda_pkg::DIGIT_W-1:0]        term_wdata;
	logic [lpda_pkg::DIGIT_W-1:0]        term_rdata;

	logic                                req_fire;
	lpda_pkg::cmd_t                      cmd;
	logic                                sat;
	logic                                slot_free;
	logic                                step_refused;

	logic [lpda_pkg::PART_W-1:0]         trial;
	logic                                ge;
	logic [lpda_pkg::PART_W-1:0]         part_sub;
	logic [lpda_pkg::PART_W-1:0]         part_x10;

	logic [lpda_pkg::DIGIT_W-1:0]        sum_d;
	logic [4:0]                          add_t;
	logic [4:0]                          sub_need;
	logic [lpda_pkg::DIGIT_W-1:0]        res_d;
	logic                                cout;

	assign cmd       = lpda_pkg::cmd_t'(command);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !slot_free;
	assign req_fire  = req_valid && !req_stall;
	assign sat       = &term_count_q;

	assign step_refused = req_fire && (cmd == lpda_pkg::CMD_STEP) && sat;

	assign rsp_valid   = rsp_valid_q;
	assign digit_value = digit_q;
	assign terms_done  = terms_q;
	assign refused     = refused_q;

	// divide step: one restoring bit per cycle, quotient bits 3 down to 0
	assign trial    = lpda_pkg::PART_W'(div_q) << bit_q;
	assign ge       = part_q >= trial;
	assign part_sub = ge ? (part_q - trial) : part_q;
	assign part_x10 = (part_sub << 3) + (part_sub << 1);

	assign term_we    = (state_q == ST_DIV) && (bit_q == 2'd0);
	assign term_wdata = {q_q, ge};

	// digits never written since reset or clear read as the start value: four at digit 0, zero elsewhere
	assign sum_d = rd_vld_s1 ? sum_rdata :
		(rd_zero_s1 ? lpda_pkg::DIGIT_W'(lpda_pkg::START_UNITS) : '0);

	assign add_t    = 5'(sum_d) + 5'(term_rdata) + 5'(cy_q);
	assign sub_need = 5'(term_rdata) + 5'(cy_q);

	always_comb begin
		if (sub_q) begin
			if (5'(sum_d) >= sub_need) begin
				res_d = 4'(5'(sum_d) - sub_need);
				cout  = 1'b0;
			end else begin
				res_d = 4'(5'(sum_d) + 5'(lpda_pkg::RADIX) - sub_need);
				cout  = 1'b1;
			end
		end else begin
			if (add_t >= 5'(lpda_pkg::RADIX)) begin
				res_d = 4'(add_t - 5'(lpda_pkg::RADIX));
				cout  = 1'b1;
			end else begin
				res_d = 4'(add_t);
				cout  = 1'b0;
			end
		end
	end

	assign sum_we    = (state_q == ST_SUM);
	assign sum_wdata = res_d;

	// sum ram read address: request read, first digit of sweep, or next more significant digit
	always_comb begin
		sum_re    = 1'b0;
		sum_raddr = k_q - 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sum_re    = req_fire && (cmd == lpda_pkg::CMD_READ);
				sum_raddr = lpda_pkg::ADDR_W'(digit_index);
			end
			ST_PRIME: begin
				sum_re    = 1'b1;
				sum_raddr = lpda_pkg::LAST_IDX;
			end
			ST_SUM: begin
				sum_re    = (k_q != '0);
				sum_raddr = k_q - 1'b1;
			end
			ST_RD_WAIT, ST_DIV: begin
				sum_re    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_re) begin
			rd_vld_s1  <= sum_vld_q[sum_raddr];
			rd_zero_s1 <= (sum_raddr == '0);
		end
	end

	lpda_ram #(
		.WIDTH(lpda_pkg::DIGIT_W),
		.DEPTH(lpda_pkg::DIGITS)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(k_q),
		.wdata(sum_wdata),
		.re   (sum_re),
		.raddr(sum_raddr),
		.rdata(sum_rdata)
	);

	// term digits share the sum sweep address
	lpda_ram #(
		.WIDTH(lpda_pkg::DIGIT_W),
		.DEPTH(lpda_pkg::DIGITS)
	) u_term_ram (
		.clk  (clk),
		.we   (term_we),
		.waddr(k_q),
		.wdata(term_wdata),
		.re   (sum_re && (state_q != ST_IDLE)),
		.raddr(sum_raddr),
		.rdata(term_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rsp_valid_q  <= 1'b0;
			term_count_q <= '0;
			sum_vld_q    <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (cmd)
							lpda_pkg::CMD_STEP: begin
								if (sat) begin
									// saturated count: answer at once, nothing changes
									rsp_valid_q <= 1'b1;
									digit_q     <= '0;
									terms_q     <= lpda_pkg::TERMS_W'(term_count_q);
									refused_q   <= 1'b1;
								end else begin
									term_count_q <= term_count_q + 1'b1;
									div_q        <= {term_count_q + 1'b1, 1'b1};
									sub_q        <= ~term_count_q[0];
									part_q       <= lpda_pkg::PART_W'(lpda_pkg::START_UNITS);
									bit_q        <= 2'd3;
									q_q          <= '0;
									k_q          <= '0;
									state_q      <= ST_DIV;
								end
							end
							lpda_pkg::CMD_READ: begin
								in_range_q <= (32'(digit_index) < lpda_pkg::DIGITS);
								state_q    <= ST_RD_WAIT;
							end
							lpda_pkg::CMD_CLEAR: begin
								sum_vld_q    <= '0;
								term_count_q <= '0;
								rsp_valid_q  <= 1'b1;
								digit_q      <= '0;
								terms_q      <= '0;
								refused_q    <= 1'b0;
							end
							lpda_pkg::CMD_NONE: begin
								rsp_valid_q <= 1'b1;
								digit_q     <= '0;
								terms_q     <= lpda_pkg::TERMS_W'(term_count_q);
								refused_q   <= 1'b0;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					rsp_valid_q <= 1'b1;
					digit_q     <= in_range_q ? sum_d : '0;
					terms_q     <= lpda_pkg::TERMS_W'(term_count_q);
					refused_q   <= 1'b0;
					state_q     <= ST_IDLE;
				end
				ST_DIV: begin
					bit_q <= bit_q - 1'b1;
					if (bit_q == 2'd0) begin
						// quotient digit written, remainder times ten for the next one
						q_q    <= '0;
						part_q <= part_x10;
						if (k_q == lpda_pkg::LAST_IDX) begin
							state_q <= ST_PRIME;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						q_q    <= {q_q[1:0], ge};
						part_q <= part_sub;
					end
				end
				ST_PRIME: begin
					k_q     <= lpda_pkg::LAST_IDX;
					cy_q    <= 1'b0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// least significant digit first, carry or borrow moves up
					cy_q           <= cout;
					sum_vld_q[k_q] <= 1'b1;
					if (k_q == '0) begin
						rsp_valid_q <= 1'b1;
						digit_q     <= '0;
						terms_q     <= lpda_pkg::TERMS_W'(term_count_q);
						refused_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
			endcase
		end
	end

	// a busy block never takes a request
	`ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, req_stall, "request taken while busy")

	// a refused step leaves the count alone and answers refused
	`ASSERT_NEXT(a_refused_holds, step_refused,
		rsp_valid_q && refused_q && $stable(term_count_q), "refused step changed state")

	// every quotient digit of the long division is decimal
	`ASSERT_NOW(a_digit_decimal, term_we, term_wdata <= 4'd9, "quotient digit above nine")

	// a stalled result stays valid and unchanged until it is taken
	`ASSERT_NEXT(a_no_overwrite, rsp_valid_q && rsp_stall,
		rsp_valid_q && $stable(digit_q) && $stable(terms_q) && $stable(refused_q),
		"result register overrun")

endmodule
